// ----- rtl/bmma_pkg.sv -----
// shared types and constants for the block matrix multiply-accumulate
package bmma_pkg;

  localparam int IDX_W       = 3;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int ACC_W       = 40;
  localparam int DIM_W       = 4;
  localparam int MAX_DIM_DEF = 8;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic             load;
    logic             clear;
    logic             mac;
    logic             first;
    logic             lastk;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic out_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/bmma_ctrl.sv -----
// sequencer: load acceptance, multiply-accumulate loop order and result streaming
module bmma_ctrl #(
  parameter int MAX_DIM = bmma_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_last_load,
  input  logic                       in_clear_first,
  input  logic                       in_emit_result,
  output logic                       in_stall,
  input  logic                       cfg_valid,
  input  logic [bmma_pkg::DIM_W-1:0] cfg_dim_in_use,
  output logic                       cfg_ready,
  input  bmma_pkg::dp_sts_t          sts,
  output bmma_pkg::dp_cmd_t          cmd
);
  import bmma_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [DIM_W-1:0] dim_r, dim_nxt;
  logic [IDX_W-1:0] dm1_r, dm1_nxt;
  logic             emit_r, emit_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] dm1_cfg;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);

  // active size clamped to 1..MAX_DIM, kept as last index
  always_comb begin
    priority if (dim_r == '0) begin
      dm1_cfg = '0;
    end else if (dim_r > DIM_W'(MAX_DIM)) begin
      dm1_cfg = IDX_W'(MAX_DIM - 1);
    end else begin
      dm1_cfg = IDX_W'(dim_r - 1'b1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    dim_nxt   = dim_r;
    dm1_nxt   = dm1_r;
    emit_nxt  = emit_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.k     = k_r;

    if (cfg_valid) begin
      dim_nxt = cfg_dim_in_use;
    end

    unique case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept && in_last_load) begin
          cmd.clear = in_clear_first;
          dm1_nxt   = dm1_cfg;
          emit_nxt  = in_emit_result;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (!sts.out_busy) begin
          cmd.mac   = 1'b1;
          cmd.first = (k_r == '0);
          cmd.lastk = (k_r == dm1_r);
          if (k_r != dm1_r) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (j_r != dm1_r) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              if (i_r != dm1_r) begin
                i_nxt = i_r + 1'b1;
              end else begin
                i_nxt     = '0;
                state_nxt = ST_DRAIN;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.mac_busy) begin
          state_nxt = emit_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (i_r == dm1_r) && (j_r == dm1_r);
          if (j_r != dm1_r) begin
            j_nxt = j_r + 1'b1;
          end else begin
            j_nxt = '0;
            if (i_r != dm1_r) begin
              i_nxt = i_r + 1'b1;
            end else begin
              i_nxt     = '0;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dim_r   <= DIM_RESET;
      dm1_r   <= '0;
      emit_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      dm1_r   <= dm1_nxt;
      emit_r  <= emit_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ----- rtl/bmma_datapath.sv -----
// element stores, accumulator memory, multiply-accumulate pipe and output word register
module bmma_datapath #(
  parameter int MAX_DIM = bmma_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmma_pkg::dp_cmd_t                 cmd,
  output bmma_pkg::dp_sts_t                 sts,
  input  logic [bmma_pkg::IDX_W-1:0]        in_row_index,
  input  logic [bmma_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [bmma_pkg::VAL_W-1:0] in_a_value,
  input  logic signed [bmma_pkg::VAL_W-1:0] in_b_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmma_pkg::IDX_W-1:0]        out_row,
  output logic [bmma_pkg::IDX_W-1:0]        out_col,
  output logic signed [bmma_pkg::ACC_W-1:0] out_c_value,
  output logic                              out_last_out
);
  import bmma_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (MAX_DIM > 1) ? $clog2(CELLS) : 1;

  logic signed [VAL_W-1:0]  a_mem [CELLS];
  logic signed [VAL_W-1:0]  b_mem [CELLS];
  logic signed [ACC_W-1:0]  c_mem [CELLS];
  logic [CELLS-1:0]         c_vld_r;

  logic [AW-1:0]            ld_addr, a_addr, b_addr, c_addr;
  logic                     ld_ok;

  logic signed [VAL_W-1:0]  a_rd_r, b_rd_r;
  logic signed [ACC_W-1:0]  c_rd_r;
  logic                     c_rd_vld_r;

  logic                     s1_vld_r, s1_first_r, s1_lastk_r;
  logic [AW-1:0]            s1_addr_r;
  logic                     s2_vld_r, s2_first_r, s2_lastk_r;
  logic [AW-1:0]            s2_addr_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  cinit_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sat;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic                     out_last_r;

  assign ld_ok   = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
  assign ld_addr = AW'(int'(in_row_index) * MAX_DIM + int'(in_col_index));
  assign a_addr  = AW'(int'(cmd.i) * MAX_DIM + int'(cmd.k));
  assign b_addr  = AW'(int'(cmd.k) * MAX_DIM + int'(cmd.j));
  assign c_addr  = AW'(int'(cmd.i) * MAX_DIM + int'(cmd.j));

  // element stores
  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) begin
      a_mem[ld_addr] <= in_a_value;
      b_mem[ld_addr] <= in_b_value;
    end
    if (cmd.mac) begin
      a_rd_r <= a_mem[a_addr];
      b_rd_r <= b_mem[b_addr];
    end
  end

  // accumulator memory, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_lastk_r) begin
      c_mem[s2_addr_r] <= sat;
    end
    if (cmd.mac || cmd.emit) begin
      c_rd_r <= c_mem[c_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r    <= '0;
      c_rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        c_vld_r <= '0;
      end else if (s2_vld_r && s2_lastk_r) begin
        c_vld_r[s2_addr_r] <= 1'b1;
      end
      if (cmd.mac || cmd.emit) begin
        c_rd_vld_r <= c_vld_r[c_addr];
      end
    end
  end

  // saturating add
  assign base = s2_first_r ? cinit_r : acc_r;
  assign sum  = {base[ACC_W-1], base}
              + {{(ACC_W + 1 - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    priority if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.mac;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.first;
    s1_lastk_r <= cmd.lastk;
    s1_addr_r  <= c_addr;
    s2_first_r <= s1_first_r;
    s2_lastk_r <= s1_lastk_r;
    s2_addr_r  <= s1_addr_r;
    prod_r     <= a_rd_r * b_rd_r;
    cinit_r    <= c_rd_vld_r ? c_rd_r : '0;
    if (s2_vld_r) begin
      acc_r <= sat;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r  <= cmd.i;
      out_col_r  <= cmd.j;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_last_out = out_last_r;
  assign out_c_value  = c_rd_vld_r ? c_rd_r : '0;

  assign sts.mac_busy = s1_vld_r || s2_vld_r;
  assign sts.out_busy = out_valid_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ----- rtl/block_matrix_multiply_accumulate.sv -----
// top level of the block matrix multiply-accumulate
//
//  port group   direction  handshake            word
//  in_          input      in_valid / in_stall  indices, a and b elements, flags
//  out_         output     out_valid/out_stall  row, column, accumulator, last mark
//  cfg_         input      cfg_valid/cfg_ready  active block size
//
// a word with last_load starts d*d*d multiply-accumulate steps, one product a cycle
// while no output word is pending, through the single multiplier, then the pipe
// drains; with emit_result, d*d output words follow at one a cycle when not stalled.
// accumulation waits until a pending output word has been taken.
// reset is synchronous; accumulator entries read as zero until written, no clear pass.
module block_matrix_multiply_accumulate #(
  parameter int MAX_DIM = bmma_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bmma_pkg::IDX_W-1:0]        in_row_index,
  input  logic [bmma_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [bmma_pkg::VAL_W-1:0] in_a_value,
  input  logic signed [bmma_pkg::VAL_W-1:0] in_b_value,
  input  logic                              in_last_load,
  input  logic                              in_clear_first,
  input  logic                              in_emit_result,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmma_pkg::IDX_W-1:0]        out_row,
  output logic [bmma_pkg::IDX_W-1:0]        out_col,
  output logic signed [bmma_pkg::ACC_W-1:0] out_c_value,
  output logic                              out_last_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmma_pkg::DIM_W-1:0]        cfg_dim_in_use
);
  import bmma_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bmma_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_load   (in_last_load),
    .in_clear_first (in_clear_first),
    .in_emit_result (in_emit_result),
    .in_stall       (in_stall),
    .cfg_valid      (cfg_valid),
    .cfg_dim_in_use (cfg_dim_in_use),
    .cfg_ready      (cfg_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  bmma_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_a_value   (in_a_value),
    .in_b_value   (in_b_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_c_value  (out_c_value),
    .out_last_out (out_last_out)
  );

  // a final load word always starts the accumulate pass
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_load |=> in_stall)
    else $error("final load word did not start accumulation");

  // a plain load word leaves the block ready
  a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_load |=> !in_stall)
    else $error("plain load word made the block busy");

  // nothing follows the final word of a block without a new input word
  a_no_word_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_out |=> !out_valid)
    else $error("output word after final word of block");

endmodule

// ----- tb/bmma_checker.sv -----
// checker for the block matrix multiply-accumulate: predicts output words and compares them
module bmma_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [bmma_pkg::IDX_W-1:0]        in_row_index,
  input  logic [bmma_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [bmma_pkg::VAL_W-1:0] in_a_value,
  input  logic signed [bmma_pkg::VAL_W-1:0] in_b_value,
  input  logic                              in_last_load,
  input  logic                              in_clear_first,
  input  logic                              in_emit_result,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [bmma_pkg::IDX_W-1:0]        out_row,
  input  logic [bmma_pkg::IDX_W-1:0]        out_col,
  input  logic signed [bmma_pkg::ACC_W-1:0] out_c_value,
  input  logic                              out_last_out,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bmma_pkg::DIM_W-1:0]        cfg_dim_in_use,
  output int                                failures,
  output int                                words_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmma_pkg::*;

  localparam int SIDE  = MAX_DIM_DEF;
  localparam int CELLS = SIDE * SIDE;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] c_value;
    logic                    last;
  } c_word_t;

  logic signed [VAL_W-1:0] a_cells [CELLS];
  logic signed [VAL_W-1:0] b_cells [CELLS];
  logic signed [ACC_W-1:0] c_cells [CELLS];
  logic [DIM_W-1:0]        dim_reg;
  c_word_t                 c_words_due [$];
  int                      fail_count;

  function automatic int active_side(input logic [DIM_W-1:0] dim);
    if (dim == 0) return 1;
    if (dim > SIDE) return SIDE;
    return int'(dim);
  endfunction

  function automatic longint clamp_acc(input longint sum);
    if (sum > longint'(ACC_MAX)) return longint'(ACC_MAX);
    if (sum < longint'(ACC_MIN)) return longint'(ACC_MIN);
    return sum;
  endfunction

  task automatic multiply_accumulate(input logic clr, input logic emit);
    int     d;
    longint sum;
    c_word_t w;
    d = active_side(dim_reg);
    if (clr) begin
      foreach (c_cells[n]) c_cells[n] = '0;
    end
    for (int i = 0; i < d; i++) begin
      for (int j = 0; j < d; j++) begin
        sum = longint'(c_cells[i*SIDE + j]);
        for (int k = 0; k < d; k++) begin
          sum = clamp_acc(sum + longint'(a_cells[i*SIDE + k]) * longint'(b_cells[k*SIDE + j]));
        end
        c_cells[i*SIDE + j] = sum[ACC_W-1:0];
      end
    end
    if (emit) begin
      for (int i = 0; i < d; i++) begin
        for (int j = 0; j < d; j++) begin
          w.row     = IDX_W'(i);
          w.col     = IDX_W'(j);
          w.c_value = c_cells[i*SIDE + j];
          w.last    = (i == d - 1) && (j == d - 1);
          c_words_due.push_back(w);
        end
      end
    end
  endtask

  task automatic check_c_word();
    c_word_t want;
    if (c_words_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: output word with none due: row %0d col %0d c %0d last %0b",
                 $realtime, out_row, out_col, out_c_value, out_last_out);
    end else begin
      want = c_words_due.pop_front();
      if (out_row !== want.row || out_col !== want.col ||
          out_c_value !== want.c_value || out_last_out !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: output word wrong, expected row %0d col %0d c %0d last %0b",
                   $realtime, want.row, want.col, want.c_value, want.last);
          $display("%0t:                    actual row %0d col %0d c %0d last %0b",
                   $realtime, out_row, out_col, out_c_value, out_last_out);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (a_cells[n]) begin
        a_cells[n] = '0;
        b_cells[n] = '0;
        c_cells[n] = '0;
      end
      dim_reg = DIM_RESET;
      c_words_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) check_c_word();
      if (cfg_valid && cfg_ready) dim_reg = cfg_dim_in_use;
      if (in_valid && !in_stall) begin
        a_cells[in_row_index*SIDE + in_col_index] = in_a_value;
        b_cells[in_row_index*SIDE + in_col_index] = in_b_value;
        if (in_last_load) multiply_accumulate(in_clear_first, in_emit_result);
      end
    end
    failures  <= fail_count;
    words_due <= c_words_due.size();
  end

endmodule

// ----- tb/tb_block_matrix_multiply_accumulate.sv -----
// testbench top for the block matrix multiply-accumulate: stimulus, watchdog and verdict
module tb_block_matrix_multiply_accumulate;
  timeunit 1ns;
  timeprecision 1ps;
  import bmma_pkg::*;

  localparam int HALF_PERIOD    = 1;
  localparam int SIDE           = MAX_DIM_DEF;
  localparam int SETTLE_CYCLES  = 600;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SAT_PASSES     = 70;

  localparam logic signed [VAL_W-1:0] Q15_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] Q15_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] Q15_NEG_ONE = '1;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [IDX_W-1:0]        in_row_index   = '0;
  logic [IDX_W-1:0]        in_col_index   = '0;
  logic signed [VAL_W-1:0] in_a_value     = '0;
  logic signed [VAL_W-1:0] in_b_value     = '0;
  logic                    in_last_load   = 1'b0;
  logic                    in_clear_first = 1'b0;
  logic                    in_emit_result = 1'b0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [ACC_W-1:0] out_c_value;
  logic                    out_last_out;
  logic                    cfg_valid      = 1'b0;
  logic                    cfg_ready;
  logic [DIM_W-1:0]        cfg_dim_in_use = DIM_RESET;

  int failures;
  int words_due;
  int quiet_cycles = 0;
  int words_sent   = 0;
  int burst_left   = 1;
  int block_dim    = int'(DIM_RESET);
  bit hold_req     = 1'b0;
  bit hold_taken   = 1'b0;

  logic [DIM_W-1:0] dim_plan [8] = '{4'd3, 4'd15, 4'd1, 4'd5, 4'd0, 4'd2, 4'd6, 4'd4};

  block_matrix_multiply_accumulate i_dut (.*);

  bmma_checker i_checker (.*);

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : receiver
    int seg_len;
    int stall_pct;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        seg_len = $urandom_range(4, 60);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 75;
          default: stall_pct = 100;
        endcase
        repeat (seg_len) begin
          @(posedge clk);
          out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] q15_sample();
    case ($urandom_range(0, 7))
      0:       return Q15_MIN;
      1:       return Q15_MAX;
      2:       return '0;
      3:       return Q15_NEG_ONE;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                           input logic signed [VAL_W-1:0] a,
                           input logic signed [VAL_W-1:0] b,
                           input logic last, input logic clr, input logic emit);
    int idle;
    in_valid       <= 1'b1;
    in_row_index   <= row;
    in_col_index   <= col;
    in_a_value     <= a;
    in_b_value     <= b;
    in_last_load   <= last;
    in_clear_first <= clr;
    in_emit_result <= emit;
    do @(posedge clk); while (in_stall);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  endtask

  task automatic send_noise();
    send_word(IDX_W'($urandom), IDX_W'($urandom), q15_sample(), q15_sample(),
              1'b0, 1'($urandom), 1'($urandom));
  endtask

  // loads the whole active block in shuffled order, the final word starts the sum
  task automatic load_block(input logic clr, input logic emit);
    int order [SIDE*SIDE];
    int count;
    int pick;
    int swap;
    count = block_dim * block_dim;
    for (int n = 0; n < count; n++) order[n] = (n / block_dim) * SIDE + n % block_dim;
    for (int n = count - 1; n > 0; n--) begin
      pick        = $urandom_range(0, n);
      swap        = order[n];
      order[n]    = order[pick];
      order[pick] = swap;
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_word(IDX_W'(order[n] / SIDE), IDX_W'(order[n] % SIDE), q15_sample(),
                q15_sample(), n == count - 1, clr, emit);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dim(input logic [DIM_W-1:0] dim);
    drain();
    cfg_valid      <= 1'b1;
    cfg_dim_in_use <= dim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    block_dim = (dim == 0) ? 1 : (dim > SIDE) ? SIDE : int'(dim);
  endtask

  initial begin : stimulus
    int spot;
    int start_count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // every store entry written at least once at the reset block size
    load_block(1'b1, 1'b1);

    set_dim(4'd1);
    send_word(3'd0, 3'd0, Q15_MIN, Q15_MIN, 1'b1, 1'b1, 1'b1);
    send_word(3'd0, 3'd0, Q15_MAX, Q15_MIN, 1'b1, 1'b0, 1'b1);
    send_word(3'd0, 3'd0, Q15_MAX, Q15_MAX, 1'b1, 1'b1, 1'b0);
    send_word(3'd7, 3'd7, 16'sh5555, 16'shAAAA, 1'b0, 1'b1, 1'b1);
    send_word(3'd0, 3'd0, '0, '0, 1'b1, 1'b0, 1'b1);
    send_word(3'd5, 3'd2, Q15_NEG_ONE, 16'sd1, 1'b0, 1'b0, 1'b0);
    send_word(3'd0, 3'd0, Q15_NEG_ONE, Q15_NEG_ONE, 1'b1, 1'b0, 1'b1);
    set_dim(4'd0);
    send_word(3'd0, 3'd0, Q15_NEG_ONE, Q15_MAX, 1'b1, 1'b1, 1'b1);
    set_dim(4'd15);
    send_word(3'd3, 3'd4, Q15_MAX, Q15_MAX, 1'b1, 1'b1, 1'b1);
    set_dim(4'd2);
    send_word(3'd0, 3'd0, Q15_MIN, Q15_MAX, 1'b0, 1'b0, 1'b0);
    send_word(3'd0, 3'd1, Q15_MAX, Q15_MIN, 1'b0, 1'b0, 1'b0);
    send_word(3'd1, 3'd0, '0, Q15_NEG_ONE, 1'b0, 1'b0, 1'b0);
    send_word(3'd1, 3'd1, Q15_NEG_ONE, Q15_MIN, 1'b1, 1'b1, 1'b1);
    send_word(3'd1, 3'd1, 16'sd1, 16'sd1, 1'b1, 1'b0, 1'b0);
    send_word(3'd6, 3'd3, Q15_MAX, Q15_NEG_ONE, 1'b1, 1'b0, 1'b1);

    // row 0 runs into the negative limit, every other row into the positive one
    set_dim(4'd8);
    for (int n = 0; n < SIDE*SIDE + SAT_PASSES; n++) begin
      spot = n % (SIDE*SIDE);
      send_word(IDX_W'(spot / SIDE), IDX_W'(spot % SIDE),
                (spot < SIDE) ? Q15_MAX : Q15_MIN, Q15_MIN, n >= SIDE*SIDE - 1,
                n == SIDE*SIDE - 1,
                (n % 16 == 15) || (n == SIDE*SIDE + SAT_PASSES - 1));
    end

    foreach (dim_plan[p]) begin
      set_dim(dim_plan[p]);
      start_count = words_sent;
      if (dim_plan[p] == 4'd2) begin
        load_block(1'b1, 1'b1);
        hold_req = 1'b1;
        repeat (3) load_block(1'b0, 1'b1);
      end
      while (words_sent - start_count < 10) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, block_dim * block_dim)) send_noise();
          1: send_word(IDX_W'($urandom), IDX_W'($urandom), q15_sample(), q15_sample(),
                       1'b1, 1'($urandom), 1'($urandom));
          default: load_block($urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0);
        endcase
      end
    end

    drain();
    if (failures == 0 && words_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
